@@ design/ps2mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Shared types and constants of the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

    localparam int POS_BITS_DEF  = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam int CURSOR_BITS   = 12;

    localparam int POS_X_RST = 160;
    localparam int POS_Y_RST = 100;

    localparam logic [11:0] X_MAX_RST       = 12'd319;
    localparam logic [11:0] Y_MAX_RST       = 12'd199;
    localparam logic [7:0]  STALL_LIMIT_RST = 8'd100;

    localparam logic [7:0]  SYNC_MASK  = 8'h08;
    localparam logic [7:0]  OVF_MASK   = 8'hC0;
    localparam int          X_SIGN_BIT = 4;
    localparam int          Y_SIGN_BIT = 5;

    localparam logic [15:0] PKT_WRAP_AT = 16'hFFFF;
    localparam logic [15:0] PKT_WRAP_TO = 16'd1000;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLICK = 2'd2,
        OP_WHEEL = 2'd3
    } t_op;

    localparam logic [1:0] BTN_NONE = 2'd3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WHEEL_MODE  = 3'd0,
        CFG_X_MAX       = 3'd1,
        CFG_Y_MAX       = 3'd2,
        CFG_STALL_LIMIT = 3'd3,
        CFG_ENABLED     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        wheel_mode;
        logic [11:0] x_max;
        logic [11:0] y_max;
        logic [7:0]  stall_limit;
        logic        enabled;
    } t_cfg;

    typedef struct packed {
        logic [CURSOR_BITS-1:0] cursor_x;
        logic [CURSOR_BITS-1:0] cursor_y;
        logic                   left_down;
        logic                   right_down;
        logic                   middle_down;
        logic signed [7:0]      wheel_last;
        logic                   clicked;
        logic signed [7:0]      wheel_taken;
        logic                   packet_done;
        logic [7:0]             resync_count;
        logic [15:0]            packet_count;
    } t_res;

endpackage

@@ design/ps2mpd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ps2mpd_cfg_regs
// Configuration register file of the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
module ps2mpd_cfg_regs import ps2mpd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WHEEL_MODE:  n_cfg.wheel_mode  = i_cfg_data[0];
                CFG_X_MAX:       n_cfg.x_max       = i_cfg_data[11:0];
                CFG_Y_MAX:       n_cfg.y_max       = i_cfg_data[11:0];
                CFG_STALL_LIMIT: n_cfg.stall_limit = i_cfg_data[7:0];
                CFG_ENABLED:     n_cfg.enabled     = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_mode  <= 1'b0;
            r_cfg.x_max       <= X_MAX_RST;
            r_cfg.y_max       <= Y_MAX_RST;
            r_cfg.stall_limit <= STALL_LIMIT_RST;
            r_cfg.enabled     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ design/ps2mpd_engine.sv @@
// ----------------------------------------------------------------------------
// ps2mpd_engine
// Decoder state and the single-pass next-state logic for one item.
// ----------------------------------------------------------------------------
module ps2mpd_engine import ps2mpd_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte,
    input  logic [1:0] i_btn,
    input  t_cfg       i_cfg,
    output t_res       o_res
);

    localparam int VW = POS_BITS + 2;
    localparam int LW = (POS_BITS > 12) ? POS_BITS : 12;
    localparam int OW = (POS_BITS > CURSOR_BITS) ? POS_BITS : CURSOR_BITS;

    function automatic logic [POS_BITS-1:0] move_clamp(
        input logic [POS_BITS-1:0] pos,
        input logic signed [9:0]   delta,
        input logic [11:0]         lim
    );
        logic [LW-1:0]        lim_e;
        logic [LW-1:0]        top_e;
        logic [LW-1:0]        bound;
        logic signed [VW-1:0] v;
        lim_e = LW'(lim);
        top_e = LW'({POS_BITS{1'b1}});
        bound = (lim_e > top_e) ? top_e : lim_e;
        v     = signed'({2'b00, pos}) + VW'(delta);
        if (v < 0) begin
            return '0;
        end else if (unsigned'(v) > VW'(bound)) begin
            return bound[POS_BITS-1:0];
        end else begin
            return v[POS_BITS-1:0];
        end
    endfunction

    logic [1:0]          r_pos,       n_pos;
    logic [7:0]          r_pkt [3];
    logic [POS_BITS-1:0] r_x,         n_x;
    logic [POS_BITS-1:0] r_y,         n_y;
    logic [2:0]          r_now,       n_now;
    logic [2:0]          r_before,    n_before;
    logic [2:0]          r_reported,  n_reported;
    logic [2:0]          r_pend,      n_pend;
    logic [7:0]          r_wstep,     n_wstep;
    logic [7:0]          r_wsum,      n_wsum;
    logic [7:0]          r_resyncs,   n_resyncs;
    logic [15:0]         r_packets,   n_packets;
    logic [15:0]         r_pat,       n_pat;
    logic [7:0]          r_stall,     n_stall;

    logic                w_drop;
    logic                w_last;
    logic                w_store;
    logic [7:0]          w_b2;
    logic signed [9:0]   w_dx;
    logic signed [9:0]   w_dy;
    logic [2:0]          f_now, f_reported, f_pend;
    logic [15:0]         w_pkt_inc;
    logic [15:0]         f_packets;
    logic [7:0]          w_stall_inc;
    logic                w_clicked;
    logic [7:0]          w_taken;
    logic                w_done;
    logic [OW-1:0]       w_x_ext, w_y_ext;

    assign w_drop  = (r_pos == 2'd0) &&
                     (((i_byte & SYNC_MASK) == 8'h00) || ((i_byte & OVF_MASK) == OVF_MASK));
    assign w_last  = i_cfg.wheel_mode ? (r_pos == 2'd3) : (r_pos >= 2'd2);
    assign w_store = i_en && (t_op'(i_op) == OP_BYTE) && !w_drop && (r_pos != 2'd3);
    assign w_b2    = (r_pos == 2'd2) ? i_byte : r_pkt[2];
    assign w_dx    = 10'(signed'({r_pkt[0][X_SIGN_BIT], r_pkt[1]}));
    assign w_dy    = 10'(signed'({r_pkt[0][Y_SIGN_BIT], w_b2}));
    assign w_pkt_inc   = r_packets + 16'd1;
    assign f_packets   = (w_pkt_inc == PKT_WRAP_AT) ? PKT_WRAP_TO : w_pkt_inc;
    assign w_stall_inc = r_stall + 8'd1;

    always_comb begin
        f_now      = r_now;
        f_reported = r_reported;
        f_pend     = r_pend;
        for (int b = 0; b < 3; b++) begin
            if (r_pkt[0][b] && !r_now[b]) begin
                if (r_pend[b]) begin
                    f_now[b]      = 1'b1;
                    f_reported[b] = 1'b0;
                    f_pend[b]     = 1'b0;
                end else begin
                    f_pend[b] = 1'b1;
                end
            end else if (!r_pkt[0][b] && r_now[b]) begin
                f_now[b]      = 1'b0;
                f_reported[b] = 1'b0;
                f_pend[b]     = 1'b0;
            end else begin
                f_pend[b] = 1'b0;
            end
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_x        = r_x;
        n_y        = r_y;
        n_now      = r_now;
        n_before   = r_before;
        n_reported = r_reported;
        n_pend     = r_pend;
        n_wstep    = r_wstep;
        n_wsum     = r_wsum;
        n_resyncs  = r_resyncs;
        n_packets  = r_packets;
        n_pat      = r_pat;
        n_stall    = r_stall;
        w_clicked  = 1'b0;
        w_taken    = 8'h00;
        w_done     = 1'b0;
        unique case (t_op'(i_op))
            OP_BYTE: begin
                if (w_drop) begin
                    n_resyncs = r_resyncs + 8'd1;
                end else if (w_last) begin
                    w_done     = 1'b1;
                    n_wstep    = i_cfg.wheel_mode ? i_byte : 8'h00;
                    n_wsum     = i_cfg.wheel_mode ? (r_wsum + i_byte) : r_wsum;
                    n_before   = r_now;
                    n_now      = f_now;
                    n_reported = f_reported;
                    n_pend     = f_pend;
                    n_x        = move_clamp(r_x, w_dx, i_cfg.x_max);
                    n_y        = move_clamp(r_y, -w_dy, i_cfg.y_max);
                    n_pos      = 2'd0;
                    n_packets  = f_packets;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            OP_TICK: begin
                if (i_cfg.enabled) begin
                    if ((r_packets == r_pat) && (r_pos != 2'd0)) begin
                        n_stall = w_stall_inc;
                        if (w_stall_inc > i_cfg.stall_limit) begin
                            n_pos     = 2'd0;
                            n_stall   = 8'd0;
                            n_resyncs = r_resyncs + 8'd1;
                        end
                    end else begin
                        n_stall = 8'd0;
                        n_pat   = r_packets;
                    end
                end
            end
            OP_CLICK: begin
                if (i_btn != BTN_NONE) begin
                    if (r_before[i_btn] && !r_now[i_btn] && !r_reported[i_btn]) begin
                        n_reported[i_btn] = 1'b1;
                        w_clicked         = 1'b1;
                    end
                end
            end
            OP_WHEEL: begin
                w_taken = r_wsum;
                n_wsum  = 8'h00;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    assign w_x_ext = OW'(n_x);
    assign w_y_ext = OW'(n_y);

    always_comb begin
        o_res.cursor_x     = w_x_ext[CURSOR_BITS-1:0];
        o_res.cursor_y     = w_y_ext[CURSOR_BITS-1:0];
        o_res.left_down    = n_now[0];
        o_res.right_down   = n_now[1];
        o_res.middle_down  = n_now[2];
        o_res.wheel_last   = signed'(n_wstep);
        o_res.clicked      = w_clicked;
        o_res.wheel_taken  = signed'(w_taken);
        o_res.packet_done  = w_done;
        o_res.resync_count = n_resyncs;
        o_res.packet_count = n_packets;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (w_store && (r_pos == 2'(k))) begin
                r_pkt[k] <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_x        <= POS_BITS'(POS_X_RST);
            r_y        <= POS_BITS'(POS_Y_RST);
            r_now      <= 3'b000;
            r_before   <= 3'b000;
            r_reported <= 3'b000;
            r_pend     <= 3'b000;
            r_wstep    <= 8'h00;
            r_wsum     <= 8'h00;
            r_resyncs  <= 8'h00;
            r_packets  <= 16'h0000;
            r_pat      <= 16'h0000;
            r_stall    <= 8'h00;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_x        <= n_x;
            r_y        <= n_y;
            r_now      <= n_now;
            r_before   <= n_before;
            r_reported <= n_reported;
            r_pend     <= n_pend;
            r_wstep    <= n_wstep;
            r_wsum     <= n_wsum;
            r_resyncs  <= n_resyncs;
            r_packets  <= n_packets;
            r_pat      <= n_pat;
            r_stall    <= n_stall;
        end
    end

    a_pkt_never_wrap_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_packets != PKT_WRAP_AT)
        else $error("packet count holds its wrap value");

    a_pend_excludes_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & r_now) == 3'b000)
        else $error("press pending on a button already down");

    a_done_restarts_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_done) |=> (r_pos == 2'd0))
        else $error("byte position not cleared after a finished packet");

endmodule

@@ design/ps2_mouse_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Top level: input register, decoder engine, result register, config port.
// ----------------------------------------------------------------------------
// One item (received byte, poll tick, click query or wheel-sum query) is
// taken per clock cycle while o_in_stall is low and gives exactly one result
// beat. An item is held in the input register until it advances and is
// decoded in one pass by the engine. Its result is then loaded into the
// output register and offered from there. Throughput is one item per cycle
// while the output side does not stall. The output register lets a new item
// be taken while a result waits to be collected. Configuration writes are
// always ready and act at once; write them only while no item is in flight.
module ps2_mouse_packet_decoder import ps2mpd_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [7:0]               i_data_byte,
    input  logic [1:0]               i_button_index,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CURSOR_BITS-1:0]   o_cursor_x,
    output logic [CURSOR_BITS-1:0]   o_cursor_y,
    output logic                     o_left_down,
    output logic                     o_right_down,
    output logic                     o_middle_down,
    output logic signed [7:0]        o_wheel_last,
    output logic                     o_clicked,
    output logic signed [7:0]        o_wheel_taken,
    output logic                     o_packet_done,
    output logic [7:0]               o_resync_count,
    output logic [15:0]              o_packet_count,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;
    logic [1:0] r_in_btn;
    logic       r_out_valid;
    t_res       r_res;
    t_res       w_res;
    t_cfg       w_cfg;
    logic       w_advance;
    logic       w_accept;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    ps2mpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ps2mpd_engine #(
        .POS_BITS (POS_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_op    (r_in_op),
        .i_byte  (r_in_byte),
        .i_btn   (r_in_btn),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
            r_in_btn  <= i_button_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_x     = r_res.cursor_x;
    assign o_cursor_y     = r_res.cursor_y;
    assign o_left_down    = r_res.left_down;
    assign o_right_down   = r_res.right_down;
    assign o_middle_down  = r_res.middle_down;
    assign o_wheel_last   = r_res.wheel_last;
    assign o_clicked      = r_res.clicked;
    assign o_wheel_taken  = r_res.wheel_taken;
    assign o_packet_done  = r_res.packet_done;
    assign o_resync_count = r_res.resync_count;
    assign o_packet_count = r_res.packet_count;

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item produced no result beat");

    a_empty_input_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    a_blocked_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |=> r_in_valid)
        else $error("pending item lost while output stalled");

endmodule
